// ----- rtl/sha256_byte_stream_hasher_defines.svh -----
// Assertion helpers shared by the hasher modules.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define S256H_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define S256H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/s256h_pkg.sv -----
package s256h_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [1:0] LAST_PART = 2'd3;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One queued item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  // Which block the schedule window is loaded with.
  typedef enum logic [2:0] {
    LOAD_DATA = 3'b001,
    LOAD_PAD1 = 3'b010,
    LOAD_PAD2 = 3'b100
  } load_mode_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_DONE  = 6'b100000
  } core_state_t;

endpackage

// ----- rtl/s256h_queue.sv -----
`include "sha256_byte_stream_hasher_defines.svh"

module s256h_queue
  import s256h_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // byte_present
  input  logic        s_tlast,   // end_of_message
  output item_t       item,
  output logic        item_valid,
  input  logic        item_pop
);

  localparam int PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;

  // Drop items that carry neither a byte nor an end mark.
  assign s_tready   = (count != CntW'(DEPTH));
  assign push       = s_tvalid && s_tready && (s_tuser[0] || s_tlast);
  assign item_valid = (count != '0);
  assign item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{data_byte: s_tdata, byte_present: s_tuser[0],
                           end_of_message: s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !item_pop) begin
        count <= count + 1'b1;
      end else if (!push && item_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `S256H_ASSERT_SAME(a_count_bound, 1'b1, count <= CntW'(DEPTH), "queue count beyond depth")
  `S256H_ASSERT_SAME(a_no_underflow, item_pop, item_valid, "pop from empty queue")
  `S256H_ASSERT_NEXT(a_count_up, push && !item_pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

// ----- rtl/s256h_core.sv -----
`include "sha256_byte_stream_hasher_defines.svh"

module s256h_core
  import s256h_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  item_t        item,
  input  logic         item_valid,
  output logic         item_pop,
  output logic [255:0] digest,
  output logic         digest_valid,
  input  logic         digest_ready
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  core_state_t  state;
  core_state_t  state_next;
  load_mode_t   mode;
  logic         pend_end;
  logic         two_blocks;
  logic [3:0]   pad_word;
  logic [5:0]   fill;
  logic [63:0]  bits;
  logic [5:0]   round;
  logic [31:0]  h   [8];
  logic [31:0]  v   [8];
  logic [31:0]  w   [16];
  logic [31:0]  blk [16];
  logic [31:0]  lw  [16];

  logic         blk_we;
  logic [7:0]   blk_byte;
  logic [4:0]   lane_sh;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  w_new;

  assign lane_sh = {~fill[1:0], 3'b000};
  assign item_pop     = (state == ST_IDLE) && item_valid;
  assign digest_valid = (state == ST_DONE);
  assign digest = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};

  // Byte write into the block buffer: pad byte in ST_PAD, message bytes otherwise.
  assign blk_we   = (item_pop && item.byte_present) || (state == ST_PAD);
  assign blk_byte = (state == ST_PAD) ? PAD_BYTE : item.data_byte;

  // Schedule window load value: plain block, padded block, or length-only block.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      case (mode)
        LOAD_DATA: lw[i] = blk[i];
        LOAD_PAD1: lw[i] = (4'(i) > pad_word) ? 32'h0 : blk[i];
        LOAD_PAD2: lw[i] = 32'h0;
        default:   lw[i] = blk[i];
      endcase
    end
    if ((mode == LOAD_PAD2) || ((mode == LOAD_PAD1) && !two_blocks)) begin
      lw[14] = bits[63:32];
      lw[15] = bits[31:0];
    end
  end

  // One compression round and one schedule step.
  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[round] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = w[0] + (rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3)) + w[9]
          + (rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.byte_present && (fill == 6'd63)) begin
            state_next = ST_LOAD;
          end else if (item.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (round == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        case (mode)
          LOAD_DATA: state_next = pend_end ? ST_PAD : ST_IDLE;
          LOAD_PAD1: state_next = two_blocks ? ST_LOAD : ST_DONE;
          LOAD_PAD2: state_next = ST_DONE;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_DONE:  if (digest_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Block buffer holds no reset; the first byte of each word overwrites it.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      if (fill[1:0] == 2'd0) begin
        blk[fill[5:2]] <= {blk_byte, 24'h0};
      end else begin
        blk[fill[5:2]][lane_sh +: 8] <= blk_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        w <= lw;
        v <= h;
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= w_new;
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= LOAD_DATA;
      pend_end   <= 1'b0;
      two_blocks <= 1'b0;
      pad_word   <= '0;
      fill       <= '0;
      bits       <= '0;
      round      <= '0;
      h          <= HASH_IV;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            pend_end <= item.end_of_message;
            mode     <= LOAD_DATA;
            if (item.byte_present) begin
              fill <= fill + 1'b1;
              bits <= bits + 64'd8;
            end
          end
        end
        ST_PAD: begin
          pad_word   <= fill[5:2];
          two_blocks <= (fill[5:3] == 3'b111);
          mode       <= LOAD_PAD1;
          pend_end   <= 1'b0;
        end
        ST_LOAD:  round <= '0;
        ST_ROUND: round <= round + 1'b1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if ((mode == LOAD_PAD1) && two_blocks) mode <= LOAD_PAD2;
        end
        ST_DONE: begin
          if (digest_ready) begin
            h    <= HASH_IV;
            fill <= '0;
            bits <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `S256H_ASSERT_SAME(a_round_wrap, state == ST_ADD, round == 6'd0, "add-back before 64 rounds")
  `S256H_ASSERT_NEXT(a_pad_to_load, state == ST_PAD, state == ST_LOAD && mode == LOAD_PAD1, "pad step did not load padded block")
  `S256H_ASSERT_NEXT(a_finish_clears, digest_valid && digest_ready, state == ST_IDLE && fill == 6'd0 && bits == 64'd0, "message state not cleared after digest")

endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// Byte input: one item per cycle while the queue has room; the idle core pops one byte a cycle.
// Each 64-byte block is compressed in steps: load, 64 rounds, add-back.
// The end item adds one final padded block, or two when the last block holds 56 bytes or more.
// Digest: four parts, back to back while m_tready is high; the next message may fill meanwhile.
// Synchronous active-high reset: initial hash value, empty block, zero bit count, empty queue.
module sha256_byte_stream_hasher
  import s256h_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // digest_part
  output logic [1:0]  m_tuser,   // part_index
  output logic        m_tlast    // last_part
);

  item_t          item;
  logic           item_valid;
  logic           item_pop;
  logic [255:0]   digest;
  logic           digest_valid;
  logic           digest_ready;

  // Output stage: a digest buffer that shifts out one 64-bit part per item.
  logic [255:0]   dig_buf;
  logic [1:0]     part;
  logic           out_busy;

  // Front: take items into a short queue, dropping empty ones.
  s256h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // Back: pack bytes, compress blocks, pad and finish.
  s256h_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop),
    .digest       (digest),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready)
  );

  // Accept a finished digest only once the previous one has fully drained.
  assign digest_ready = !out_busy;

  assign m_tvalid = out_busy;
  assign m_tdata  = dig_buf[255:192];
  assign m_tuser  = part;
  assign m_tlast  = (part == LAST_PART);

  // Hold the digest payload; advance one part per accepted item.
  always_ff @(posedge clk) begin
    if (digest_valid && digest_ready) begin
      dig_buf <= digest;
    end else if (m_tvalid && m_tready) begin
      dig_buf <= {dig_buf[191:0], 64'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      part     <= '0;
    end else if (digest_valid && digest_ready) begin
      out_busy <= 1'b1;
      part     <= '0;
    end else if (m_tvalid && m_tready) begin
      part <= part + 1'b1;
      if (part == LAST_PART) begin
        out_busy <= 1'b0;
      end
    end
  end

endmodule
